// ===== hw/rtl/fbsm_pkg.sv =====
// Shared types, constants and a search helper for the frame buffer swap manager.
`default_nettype none

package fbsm_pkg;

    localparam int NUM_BUFFERS = 3;
    localparam int SLOT_W      = 2;
    localparam int MASK_W      = 3;
    localparam int PERIOD_W    = 6;
    localparam int COUNT_W     = 6;
    localparam int NB_W        = 2;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [MASK_W-1:0]   MASK_RESET   = 3'd7;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 6'd60;
    localparam logic [COUNT_W-1:0]  COUNT_MAX    = 6'd63;

    typedef enum logic [0:0] {
        REG_PRESENT_MASK   = 1'b0,
        REG_RETRACE_PERIOD = 1'b1
    } t_reg;

    typedef enum logic [2:0] {
        OP_INIT         = 3'd0,
        OP_ACQUIRE      = 3'd1,
        OP_SUBMIT       = 3'd2,
        OP_DRAW_DONE    = 3'd3,
        OP_PRE_RETRACE  = 3'd4,
        OP_POST_RETRACE = 3'd5,
        OP_SETTINGS_CHG = 3'd6,
        OP_EFB_DRAWN    = 3'd7
    } t_opcode;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_FREE     = 3'd1,
        ST_DRAWING  = 3'd2,
        ST_WAITDONE = 3'd3,
        ST_DRAWDONE = 3'd4,
        ST_NEXT     = 3'd5,
        ST_DISPLAY  = 3'd6,
        ST_COPYEFB  = 3'd7
    } t_status;

    typedef t_status [NUM_BUFFERS-1:0] t_status_vec;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] idx;
    } t_find;

    typedef struct packed {
        logic [MASK_W-1:0]   present_mask;
        logic [PERIOD_W-1:0] retrace_period;
    } t_cfg;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_room;
    } t_dp_status;

    typedef struct packed {
        logic               found;
        logic [SLOT_W-1:0]  slot;
        logic               show_buffer;
        logic               reconfigure;
        logic               flush;
        logic               copy_efb;
        logic               error;
        logic               last_done_valid;
        logic [SLOT_W-1:0]  last_done_slot;
        logic               flush_pending;
        logic [COUNT_W-1:0] frames_renewed;
    } t_result;

    // lowest index holding the given status
    function automatic t_find find_status(input t_status_vec st, input t_status code);
        t_find f;
        f = '0;
        for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
            if (st[i] == code) begin
                f.hit = 1'b1;
                f.idx = SLOT_W'(i);
            end
        end
        return f;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fbsm_if.sv =====
// Valid/ready channel interfaces for the item and result beats.
`default_nettype none

interface fbsm_in_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    opcode;
    logic [fbsm_pkg::SLOT_W-1:0]   buffer_index;

    modport source (output valid, output opcode, output buffer_index, input ready);
    modport sink   (input valid, input opcode, input buffer_index, output ready);
endinterface

interface fbsm_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [fbsm_pkg::SLOT_W-1:0]   slot;
    logic                          show_buffer;
    logic                          reconfigure;
    logic                          flush;
    logic                          copy_efb;
    logic                          error;
    logic                          last_done_valid;
    logic [fbsm_pkg::SLOT_W-1:0]   last_done_slot;
    logic                          flush_pending;
    logic [fbsm_pkg::COUNT_W-1:0]  frames_renewed;

    modport source (
        output valid, output found, output slot, output show_buffer, output reconfigure,
        output flush, output copy_efb, output error, output last_done_valid,
        output last_done_slot, output flush_pending, output frames_renewed, input ready
    );
    modport sink (
        input valid, input found, input slot, input show_buffer, input reconfigure,
        input flush, input copy_efb, input error, input last_done_valid,
        input last_done_slot, input flush_pending, input frames_renewed, output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/frame_buffer_swap_manager.sv =====
// Top level: frame buffer swap manager with item/result channels and APB registers.
// An accepted item beat is latched into the opcode and index registers, then executed
// into the result register. No new item is taken until the last one has executed; the
// controller holds an item in its execute step until the single result register has room.
// Reset (synchronous, active low): all buffers none, flags and counters zero,
// present_mask 7, retrace period 60; no result beat pending.
`default_nettype none

module frame_buffer_swap_manager (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    fbsm_in_if.sink                          i_item,
    fbsm_out_if.source                       o_result,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fbsm_pkg::APB_AW-1:0] paddr,
    input  wire logic [fbsm_pkg::APB_DW-1:0] pwdata,
    output logic      [fbsm_pkg::APB_DW-1:0] prdata,
    output logic                             pready
);

    fbsm_pkg::t_cfg       w_cfg;
    fbsm_pkg::t_cmd       w_cmd;
    fbsm_pkg::t_dp_status w_dp_status;
    fbsm_pkg::t_result    w_out;
    logic                 w_ready;
    logic                 w_out_valid;

    fbsm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fbsm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_item.valid),
        .o_ready  (w_ready),
        .i_status (w_dp_status),
        .o_cmd    (w_cmd)
    );

    fbsm_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_dp_status),
        .i_cfg          (w_cfg),
        .i_opcode       (i_item.opcode),
        .i_buffer_index (i_item.buffer_index),
        .o_out_valid    (w_out_valid),
        .i_out_ready    (o_result.ready),
        .o_out          (w_out)
    );

    assign i_item.ready             = w_ready;
    assign o_result.valid           = w_out_valid;
    assign o_result.found           = w_out.found;
    assign o_result.slot            = w_out.slot;
    assign o_result.show_buffer     = w_out.show_buffer;
    assign o_result.reconfigure     = w_out.reconfigure;
    assign o_result.flush           = w_out.flush;
    assign o_result.copy_efb        = w_out.copy_efb;
    assign o_result.error           = w_out.error;
    assign o_result.last_done_valid = w_out.last_done_valid;
    assign o_result.last_done_slot  = w_out.last_done_slot;
    assign o_result.flush_pending   = w_out.flush_pending;
    assign o_result.frames_renewed  = w_out.frames_renewed;

endmodule

`default_nettype wire

// ===== hw/rtl/fbsm_cfg.sv =====
// APB register block holding the buffer presence mask and the retrace period.
`default_nettype none

module fbsm_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fbsm_pkg::APB_AW-1:0] paddr,
    input  wire logic [fbsm_pkg::APB_DW-1:0] pwdata,
    output logic      [fbsm_pkg::APB_DW-1:0] prdata,
    output logic                             pready,
    output fbsm_pkg::t_cfg                   o_cfg
);

    logic [fbsm_pkg::MASK_W-1:0]   r_present_mask;
    logic [fbsm_pkg::PERIOD_W-1:0] r_retrace_period;
    fbsm_pkg::t_reg                w_reg;
    logic                          w_wr;

    assign pready = 1'b1;
    // byte address 4*i: bit 2 picks the register
    assign w_reg  = fbsm_pkg::t_reg'(paddr[2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present_mask   <= fbsm_pkg::MASK_RESET;
            r_retrace_period <= fbsm_pkg::PERIOD_RESET;
        end else if (w_wr) begin
            case (w_reg)
                fbsm_pkg::REG_PRESENT_MASK: begin
                    r_present_mask <= pwdata[fbsm_pkg::MASK_W-1:0];
                end
                fbsm_pkg::REG_RETRACE_PERIOD: begin
                    r_retrace_period <= pwdata[fbsm_pkg::PERIOD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            fbsm_pkg::REG_PRESENT_MASK: begin
                prdata = fbsm_pkg::APB_DW'(r_present_mask);
            end
            fbsm_pkg::REG_RETRACE_PERIOD: begin
                prdata = fbsm_pkg::APB_DW'(r_retrace_period);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign o_cfg.present_mask   = r_present_mask;
    assign o_cfg.retrace_period = r_retrace_period;

endmodule

`default_nettype wire

// ===== hw/rtl/fbsm_ctrl.sv =====
// Controller: takes one item beat, then runs it once the result register has room.
`default_nettype none

module fbsm_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  fbsm_pkg::t_dp_status       i_status,
    output fbsm_pkg::t_cmd             o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_status.out_room) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && i_valid;
    assign o_cmd.exec = (r_state == S_EXEC) && i_status.out_room;

endmodule

`default_nettype wire

// ===== hw/rtl/fbsm_dp.sv =====
// Datapath: buffer status table, flags, retrace counters and result register.
`default_nettype none

module fbsm_dp (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  fbsm_pkg::t_cmd                   i_cmd,
    output fbsm_pkg::t_dp_status             o_status,
    input  fbsm_pkg::t_cfg                   i_cfg,
    input  wire logic [2:0]                  i_opcode,
    input  wire logic [fbsm_pkg::SLOT_W-1:0] i_buffer_index,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output fbsm_pkg::t_result                o_out
);

    fbsm_pkg::t_opcode                  r_op;
    logic [fbsm_pkg::SLOT_W-1:0]        r_bi;

    fbsm_pkg::t_status_vec              r_status;
    logic [fbsm_pkg::NUM_BUFFERS-1:0]   r_changed;
    logic                               r_settings_changed;
    logic                               r_efb_ready;
    logic                               r_efb_changed;
    logic [fbsm_pkg::PERIOD_W-1:0]      r_retrace_count;
    logic [fbsm_pkg::COUNT_W-1:0]       r_renew_count;
    logic [fbsm_pkg::COUNT_W-1:0]       r_renew_result;

    fbsm_pkg::t_status_vec              n_status;
    logic [fbsm_pkg::NUM_BUFFERS-1:0]   n_changed;
    logic                               n_settings_changed;
    logic                               n_efb_ready;
    logic                               n_efb_changed;
    logic [fbsm_pkg::PERIOD_W-1:0]      n_retrace_count;
    logic [fbsm_pkg::COUNT_W-1:0]       n_renew_count;
    logic [fbsm_pkg::COUNT_W-1:0]       n_renew_result;
    fbsm_pkg::t_result                  n_out;

    logic                               r_out_valid;
    fbsm_pkg::t_result                  r_out;
    logic [fbsm_pkg::NUM_BUFFERS-1:0]   w_is_next;

    always_comb begin
        fbsm_pkg::t_find            f_a;
        fbsm_pkg::t_find            f_b;
        logic [fbsm_pkg::NB_W-1:0]  nb;
        logic                       bi_ok;
        logic                       renew;
        logic [fbsm_pkg::PERIOD_W:0] rc;

        n_status           = r_status;
        n_changed          = r_changed;
        n_settings_changed = r_settings_changed;
        n_efb_ready        = r_efb_ready;
        n_efb_changed      = r_efb_changed;
        n_retrace_count    = r_retrace_count;
        n_renew_count      = r_renew_count;
        n_renew_result     = r_renew_result;
        n_out              = '0;
        renew              = 1'b0;
        f_a                = '0;
        f_b                = '0;
        nb    = fbsm_pkg::NB_W'($countones(i_cfg.present_mask));
        bi_ok = (int'(r_bi) < fbsm_pkg::NUM_BUFFERS);
        rc    = {1'b0, r_retrace_count} + 1'b1;

        case (r_op)
            fbsm_pkg::OP_INIT: begin
                for (int i = 0; i < fbsm_pkg::NUM_BUFFERS; i++) begin
                    n_status[i]  = i_cfg.present_mask[i] ? fbsm_pkg::ST_FREE
                                                         : fbsm_pkg::ST_NONE;
                    n_changed[i] = 1'b0;
                end
                n_settings_changed = 1'b0;
                n_efb_ready        = 1'b0;
                n_efb_changed      = 1'b0;
                n_renew_result     = '0;
            end
            fbsm_pkg::OP_ACQUIRE: begin
                if (nb >= 2'd2) begin
                    f_a = fbsm_pkg::find_status(r_status, fbsm_pkg::ST_DRAWING);
                    if (!f_a.hit) begin
                        f_a = fbsm_pkg::find_status(r_status, fbsm_pkg::ST_FREE);
                        if (f_a.hit) begin
                            n_status[f_a.idx] = fbsm_pkg::ST_DRAWING;
                        end
                    end
                    n_out.found = f_a.hit;
                    n_out.slot  = f_a.hit ? f_a.idx : '0;
                end
            end
            fbsm_pkg::OP_SUBMIT: begin
                if (bi_ok && r_status[r_bi] == fbsm_pkg::ST_DRAWING) begin
                    n_status[r_bi]     = fbsm_pkg::ST_WAITDONE;
                    n_changed[r_bi]    = r_settings_changed;
                    n_settings_changed = 1'b0;
                end else begin
                    n_out.error = 1'b1;
                end
            end
            fbsm_pkg::OP_DRAW_DONE: begin
                if (bi_ok && r_status[r_bi] == fbsm_pkg::ST_WAITDONE) begin
                    f_a = fbsm_pkg::find_status(r_status, fbsm_pkg::ST_NEXT);
                    n_status[r_bi] = f_a.hit ? fbsm_pkg::ST_DRAWDONE : fbsm_pkg::ST_NEXT;
                end else begin
                    n_out.error = 1'b1;
                end
            end
            fbsm_pkg::OP_PRE_RETRACE: begin
                f_a = fbsm_pkg::find_status(r_status, fbsm_pkg::ST_NEXT);
                if (f_a.hit) begin
                    n_out.show_buffer = 1'b1;
                    n_out.slot        = f_a.idx;
                    n_out.reconfigure = r_changed[f_a.idx];
                    n_out.flush       = 1'b1;
                    renew             = 1'b1;
                end else if (nb == 2'd1 && r_efb_ready) begin
                    // single buffer: reuse the displayed one, else take a free one
                    f_b = fbsm_pkg::find_status(r_status, fbsm_pkg::ST_DISPLAY);
                    if (!f_b.hit) begin
                        f_b = fbsm_pkg::find_status(r_status, fbsm_pkg::ST_FREE);
                        if (f_b.hit) begin
                            n_out.show_buffer = 1'b1;
                            n_out.slot        = f_b.idx;
                            n_out.flush       = 1'b1;
                        end
                    end
                    if (f_b.hit) begin
                        n_status[f_b.idx] = fbsm_pkg::ST_COPYEFB;
                        if (r_efb_changed) begin
                            n_out.reconfigure = 1'b1;
                            n_out.flush       = 1'b1;
                        end
                        renew = 1'b1;
                    end
                end
                if (renew && r_renew_count != fbsm_pkg::COUNT_MAX) begin
                    n_renew_count = r_renew_count + 1'b1;
                end
                if (rc >= {1'b0, i_cfg.retrace_period}) begin
                    n_renew_result  = n_renew_count;
                    n_retrace_count = '0;
                    n_renew_count   = '0;
                end else begin
                    n_retrace_count = rc[fbsm_pkg::PERIOD_W-1:0];
                end
            end
            fbsm_pkg::OP_POST_RETRACE: begin
                f_a = fbsm_pkg::find_status(r_status, fbsm_pkg::ST_NEXT);
                if (f_a.hit) begin
                    f_b = fbsm_pkg::find_status(r_status, fbsm_pkg::ST_DISPLAY);
                    if (f_b.hit) begin
                        n_status[f_b.idx] = fbsm_pkg::ST_FREE;
                    end
                    n_status[f_a.idx] = fbsm_pkg::ST_DISPLAY;
                    // draw-done entries are untouched above, so search the old table
                    f_b = fbsm_pkg::find_status(r_status, fbsm_pkg::ST_DRAWDONE);
                    if (f_b.hit) begin
                        n_status[f_b.idx] = fbsm_pkg::ST_NEXT;
                    end
                end else begin
                    f_b = fbsm_pkg::find_status(r_status, fbsm_pkg::ST_COPYEFB);
                    if (f_b.hit) begin
                        n_out.copy_efb    = 1'b1;
                        n_out.slot        = f_b.idx;
                        n_status[f_b.idx] = fbsm_pkg::ST_DISPLAY;
                        n_efb_ready       = 1'b0;
                    end
                end
            end
            fbsm_pkg::OP_SETTINGS_CHG: begin
                n_settings_changed = 1'b1;
            end
            fbsm_pkg::OP_EFB_DRAWN: begin
                n_efb_ready        = 1'b1;
                n_efb_changed      = r_settings_changed;
                n_settings_changed = 1'b0;
            end
            default: begin
            end
        endcase

        // summary of the table after the update
        f_a = fbsm_pkg::find_status(n_status, fbsm_pkg::ST_WAITDONE);
        if (!f_a.hit) f_a = fbsm_pkg::find_status(n_status, fbsm_pkg::ST_DRAWDONE);
        if (!f_a.hit) f_a = fbsm_pkg::find_status(n_status, fbsm_pkg::ST_NEXT);
        if (!f_a.hit) f_a = fbsm_pkg::find_status(n_status, fbsm_pkg::ST_DISPLAY);
        n_out.last_done_valid = f_a.hit;
        n_out.last_done_slot  = f_a.hit ? f_a.idx : '0;
        n_out.flush_pending   = (nb >= 2'd2) && f_a.hit &&
                                (n_status[f_a.idx] != fbsm_pkg::ST_DISPLAY);
        n_out.frames_renewed  = n_renew_result;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= fbsm_pkg::t_opcode'(i_opcode);
            r_bi <= i_buffer_index;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fbsm_pkg::NUM_BUFFERS; i++) begin
                r_status[i] <= fbsm_pkg::ST_NONE;
            end
            r_changed          <= '0;
            r_settings_changed <= 1'b0;
            r_efb_ready        <= 1'b0;
            r_efb_changed      <= 1'b0;
            r_retrace_count    <= '0;
            r_renew_count      <= '0;
            r_renew_result     <= '0;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_status           <= n_status;
                r_changed          <= n_changed;
                r_settings_changed <= n_settings_changed;
                r_efb_ready        <= n_efb_ready;
                r_efb_changed      <= n_efb_changed;
                r_retrace_count    <= n_retrace_count;
                r_renew_count      <= n_renew_count;
                r_renew_result     <= n_renew_result;
                r_out_valid        <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_room = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out             = r_out;

    always_comb begin
        for (int i = 0; i < fbsm_pkg::NUM_BUFFERS; i++) begin
            w_is_next[i] = (r_status[i] == fbsm_pkg::ST_NEXT);
        end
    end

    a_exec_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("executed item left no result beat");

    a_single_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_is_next) <= 1)
        else $error("more than one buffer marked next");

    a_pending_has_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.flush_pending |-> r_out.last_done_valid)
        else $error("flush pending without a finished buffer");

    a_show_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.show_buffer |-> r_out.flush)
        else $error("buffer shown without a flush");

endmodule

`default_nettype wire

// ===== tb/fbsm_checker.sv =====
// Checker for the swap manager: tracks buffer status, predicts each result beat and compares.
`timescale 1ns / 1ps

module fbsm_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    fbsm_in_if                                 i_item,
    fbsm_out_if                                i_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic                          pready,
    input  wire logic [fbsm_pkg::APB_AW-1:0]   paddr,
    input  wire logic [fbsm_pkg::APB_DW-1:0]   pwdata,
    output int                                 o_fail_count,
    output int                                 o_pending
);

    logic [fbsm_pkg::MASK_W-1:0]   cfg_mask;
    logic [fbsm_pkg::PERIOD_W-1:0] cfg_period;

    fbsm_pkg::t_status             buf_state [fbsm_pkg::NUM_BUFFERS];
    logic                          buf_dirty [fbsm_pkg::NUM_BUFFERS];
    logic                          settings_dirty;
    logic                          efb_ready;
    logic                          efb_dirty;
    logic [fbsm_pkg::COUNT_W-1:0]  retrace_cnt;
    logic [fbsm_pkg::COUNT_W-1:0]  renew_cnt;
    logic [fbsm_pkg::COUNT_W-1:0]  renew_last;

    fbsm_pkg::t_result             due_results [$];
    fbsm_pkg::t_result             want;
    int                            fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic int first_with(input fbsm_pkg::t_status code);
        for (int i = 0; i < fbsm_pkg::NUM_BUFFERS; i++) begin
            if (buf_state[i] == code) return i;
        end
        return -1;
    endfunction

    // advances the buffer state by one item and returns the result it gives
    function automatic fbsm_pkg::t_result swap_step(input fbsm_pkg::t_opcode op,
                                                    input logic [fbsm_pkg::SLOT_W-1:0] bi);
        fbsm_pkg::t_result          r;
        int                         nb;
        int                         idx;
        int                         nx;
        logic                       renew;
        logic [fbsm_pkg::COUNT_W:0] rc;
        r     = '0;
        nb    = $countones(cfg_mask);
        renew = 1'b0;
        case (op)
            fbsm_pkg::OP_INIT: begin
                for (int i = 0; i < fbsm_pkg::NUM_BUFFERS; i++) begin
                    buf_state[i] = cfg_mask[i] ? fbsm_pkg::ST_FREE : fbsm_pkg::ST_NONE;
                    buf_dirty[i] = 1'b0;
                end
                settings_dirty = 1'b0;
                efb_ready      = 1'b0;
                efb_dirty      = 1'b0;
                renew_last     = '0;
            end
            fbsm_pkg::OP_ACQUIRE: begin
                if (nb >= 2) begin
                    idx = first_with(fbsm_pkg::ST_DRAWING);
                    if (idx < 0) begin
                        idx = first_with(fbsm_pkg::ST_FREE);
                        if (idx >= 0) buf_state[idx] = fbsm_pkg::ST_DRAWING;
                    end
                    if (idx >= 0) begin
                        r.found = 1'b1;
                        r.slot  = fbsm_pkg::SLOT_W'(idx);
                    end
                end
            end
            fbsm_pkg::OP_SUBMIT: begin
                if (int'(bi) < fbsm_pkg::NUM_BUFFERS &&
                    buf_state[bi] == fbsm_pkg::ST_DRAWING) begin
                    buf_state[bi]  = fbsm_pkg::ST_WAITDONE;
                    buf_dirty[bi]  = settings_dirty;
                    settings_dirty = 1'b0;
                end else begin
                    r.error = 1'b1;
                end
            end
            fbsm_pkg::OP_DRAW_DONE: begin
                if (int'(bi) < fbsm_pkg::NUM_BUFFERS &&
                    buf_state[bi] == fbsm_pkg::ST_WAITDONE) begin
                    buf_state[bi] = (first_with(fbsm_pkg::ST_NEXT) >= 0) ?
                                    fbsm_pkg::ST_DRAWDONE : fbsm_pkg::ST_NEXT;
                end else begin
                    r.error = 1'b1;
                end
            end
            fbsm_pkg::OP_PRE_RETRACE: begin
                idx = first_with(fbsm_pkg::ST_NEXT);
                if (idx >= 0) begin
                    r.show_buffer = 1'b1;
                    r.slot        = fbsm_pkg::SLOT_W'(idx);
                    r.reconfigure = buf_dirty[idx];
                    r.flush       = 1'b1;
                    renew         = 1'b1;
                end else if (nb == 1 && efb_ready) begin
                    // single buffer: reuse the displayed one, else take a free one
                    idx = first_with(fbsm_pkg::ST_DISPLAY);
                    if (idx < 0) begin
                        idx = first_with(fbsm_pkg::ST_FREE);
                        if (idx >= 0) begin
                            r.show_buffer = 1'b1;
                            r.slot        = fbsm_pkg::SLOT_W'(idx);
                            r.flush       = 1'b1;
                        end
                    end
                    if (idx >= 0) begin
                        buf_state[idx] = fbsm_pkg::ST_COPYEFB;
                        if (efb_dirty) begin
                            r.reconfigure = 1'b1;
                            r.flush       = 1'b1;
                        end
                        renew = 1'b1;
                    end
                end
                if (renew && renew_cnt != fbsm_pkg::COUNT_MAX) renew_cnt = renew_cnt + 1'b1;
                rc = {1'b0, retrace_cnt} + 1'b1;
                if (rc >= {1'b0, cfg_period}) begin
                    renew_last  = renew_cnt;
                    retrace_cnt = '0;
                    renew_cnt   = '0;
                end else begin
                    retrace_cnt = rc[fbsm_pkg::COUNT_W-1:0];
                end
            end
            fbsm_pkg::OP_POST_RETRACE: begin
                nx = first_with(fbsm_pkg::ST_NEXT);
                if (nx >= 0) begin
                    idx = first_with(fbsm_pkg::ST_DISPLAY);
                    if (idx >= 0) buf_state[idx] = fbsm_pkg::ST_FREE;
                    buf_state[nx] = fbsm_pkg::ST_DISPLAY;
                    idx = first_with(fbsm_pkg::ST_DRAWDONE);
                    if (idx >= 0) buf_state[idx] = fbsm_pkg::ST_NEXT;
                end else begin
                    idx = first_with(fbsm_pkg::ST_COPYEFB);
                    if (idx >= 0) begin
                        r.copy_efb     = 1'b1;
                        r.slot         = fbsm_pkg::SLOT_W'(idx);
                        buf_state[idx] = fbsm_pkg::ST_DISPLAY;
                        efb_ready      = 1'b0;
                    end
                end
            end
            fbsm_pkg::OP_SETTINGS_CHG: begin
                settings_dirty = 1'b1;
            end
            default: begin
                efb_ready      = 1'b1;
                efb_dirty      = settings_dirty;
                settings_dirty = 1'b0;
            end
        endcase

        idx = first_with(fbsm_pkg::ST_WAITDONE);
        if (idx < 0) idx = first_with(fbsm_pkg::ST_DRAWDONE);
        if (idx < 0) idx = first_with(fbsm_pkg::ST_NEXT);
        if (idx < 0) idx = first_with(fbsm_pkg::ST_DISPLAY);
        if (idx >= 0) begin
            r.last_done_valid = 1'b1;
            r.last_done_slot  = fbsm_pkg::SLOT_W'(idx);
        end
        r.flush_pending = (nb >= 2) && (first_with(fbsm_pkg::ST_WAITDONE) >= 0 ||
                          first_with(fbsm_pkg::ST_DRAWDONE) >= 0 ||
                          first_with(fbsm_pkg::ST_NEXT) >= 0);
        r.frames_renewed = renew_last;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_mask       = fbsm_pkg::MASK_RESET;
            cfg_period     = fbsm_pkg::PERIOD_RESET;
            for (int i = 0; i < fbsm_pkg::NUM_BUFFERS; i++) begin
                buf_state[i] = fbsm_pkg::ST_NONE;
                buf_dirty[i] = 1'b0;
            end
            settings_dirty = 1'b0;
            efb_ready      = 1'b0;
            efb_dirty      = 1'b0;
            retrace_cnt    = '0;
            renew_cnt      = '0;
            renew_last     = '0;
            due_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (fbsm_pkg::t_reg'(paddr[2]))
                    fbsm_pkg::REG_PRESENT_MASK:   cfg_mask   = pwdata[fbsm_pkg::MASK_W-1:0];
                    fbsm_pkg::REG_RETRACE_PERIOD: cfg_period = pwdata[fbsm_pkg::PERIOD_W-1:0];
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready)
                due_results.push_back(swap_step(fbsm_pkg::t_opcode'(i_item.opcode),
                                                i_item.buffer_index));
            if (i_result.valid && i_result.ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    fail_total++;
                end else begin
                    want = due_results.pop_front();
                    check_field("found", want.found, i_result.found);
                    check_field("slot", want.slot, i_result.slot);
                    check_field("show_buffer", want.show_buffer, i_result.show_buffer);
                    check_field("reconfigure", want.reconfigure, i_result.reconfigure);
                    check_field("flush", want.flush, i_result.flush);
                    check_field("copy_efb", want.copy_efb, i_result.copy_efb);
                    check_field("error", want.error, i_result.error);
                    check_field("last_done_valid", want.last_done_valid,
                                i_result.last_done_valid);
                    check_field("last_done_slot", want.last_done_slot,
                                i_result.last_done_slot);
                    check_field("flush_pending", want.flush_pending, i_result.flush_pending);
                    check_field("frames_renewed", want.frames_renewed,
                                i_result.frames_renewed);
                end
            end
        end
        o_pending <= due_results.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Testbench top: clock, reset, item and register stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int QUIET_LIMIT = 4000;
    localparam int N_PHASES    = 10;
    localparam logic [fbsm_pkg::MASK_W-1:0]   PHASE_MASK   [N_PHASES] =
        '{3'd7, 3'd3, 3'd1, 3'd5, 3'd0, 3'd6, 3'd4, 3'd2, 3'd7, 3'd7};
    localparam logic [fbsm_pkg::PERIOD_W-1:0] PHASE_PERIOD [N_PHASES] =
        '{6'd63, 6'd2, 6'd5, 6'd1, 6'd3, 6'd50, 6'd1, 6'd7, 6'd13, 6'd60};

    logic                        i_clk   = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [fbsm_pkg::APB_AW-1:0] paddr   = '0;
    logic [fbsm_pkg::APB_DW-1:0] pwdata  = '0;
    logic [fbsm_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    logic                        out_ready = 1'b0;
    logic                        idle_en   = 1'b0;
    logic [fbsm_pkg::SLOT_W-1:0] acq_slot  = '0;
    logic [fbsm_pkg::MASK_W-1:0] cur_mask  = fbsm_pkg::MASK_RESET;
    int                          stall_left = 0;
    int                          quiet = 0;
    int                          items_sent = 0;
    int                          fail_count;
    int                          pending;

    fbsm_in_if  item_bus ();
    fbsm_out_if result_bus ();

    assign result_bus.ready = out_ready;

    frame_buffer_swap_manager u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_result(result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    fbsm_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (item_bus),
        .i_result    (result_bus),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 i_clk = ~i_clk;

    // result side stalls in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready  <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) out_ready <= 1'b1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(1, 10);
        end
    end

    // slot handed out by the latest successful acquire, used to build well-formed frames
    always @(posedge i_clk) begin
        if (result_bus.valid && result_bus.ready && result_bus.found)
            acq_slot <= result_bus.slot;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (item_bus.valid && item_bus.ready) ||
            (result_bus.valid && result_bus.ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet == QUIET_LIMIT) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    task automatic send_op(input fbsm_pkg::t_opcode op,
                           input logic [fbsm_pkg::SLOT_W-1:0] bi);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            item_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        item_bus.valid        <= 1'b1;
        item_bus.opcode       <= op;
        item_bus.buffer_index <= bi;
        do @(posedge i_clk); while (!item_bus.ready);
        items_sent++;
    endtask

    // stop sending and wait for every outstanding result beat
    task automatic settle();
        item_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic cfg_write(input fbsm_pkg::t_reg r, input logic [fbsm_pkg::APB_DW-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [fbsm_pkg::SLOT_W-1:0] any_bi();
        return fbsm_pkg::SLOT_W'($urandom_range(0, 3));
    endfunction

    task automatic play_frame();
        logic [fbsm_pkg::SLOT_W-1:0] s;
        if ($urandom_range(0, 3) == 0) send_op(fbsm_pkg::OP_SETTINGS_CHG, any_bi());
        if ($countones(cur_mask) == 1) begin
            if ($urandom_range(0, 3) != 0) send_op(fbsm_pkg::OP_EFB_DRAWN, any_bi());
        end else begin
            send_op(fbsm_pkg::OP_ACQUIRE, any_bi());
            if ($urandom_range(0, 3) != 0) begin
                settle();
                s = acq_slot;
            end else begin
                s = fbsm_pkg::SLOT_W'($urandom_range(0, 2));
            end
            send_op(fbsm_pkg::OP_SUBMIT, s);
            if ($urandom_range(0, 4) == 0) send_op(fbsm_pkg::OP_EFB_DRAWN, any_bi());
            send_op(fbsm_pkg::OP_DRAW_DONE, s);
        end
        if ($urandom_range(0, 2) != 0) send_op(fbsm_pkg::OP_PRE_RETRACE, any_bi());
        if ($urandom_range(0, 2) != 0) send_op(fbsm_pkg::OP_POST_RETRACE, any_bi());
    endtask

    initial begin
        int target;
        int pick;
        item_bus.valid        = 1'b0;
        item_bus.opcode       = fbsm_pkg::OP_INIT;
        item_bus.buffer_index = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_en <= 1'b1;

        // three buffers, reset settings; acquire and submit before init find nothing
        send_op(fbsm_pkg::OP_ACQUIRE, 2'd0);
        send_op(fbsm_pkg::OP_SUBMIT, 2'd0);
        send_op(fbsm_pkg::OP_INIT, 2'd3);
        send_op(fbsm_pkg::OP_ACQUIRE, 2'd0);
        send_op(fbsm_pkg::OP_ACQUIRE, 2'd1);
        send_op(fbsm_pkg::OP_SETTINGS_CHG, 2'd2);
        send_op(fbsm_pkg::OP_SUBMIT, 2'd0);
        send_op(fbsm_pkg::OP_DRAW_DONE, 2'd3);
        send_op(fbsm_pkg::OP_DRAW_DONE, 2'd0);
        send_op(fbsm_pkg::OP_ACQUIRE, 2'd0);
        send_op(fbsm_pkg::OP_SUBMIT, 2'd1);
        send_op(fbsm_pkg::OP_DRAW_DONE, 2'd1);
        send_op(fbsm_pkg::OP_PRE_RETRACE, 2'd0);
        send_op(fbsm_pkg::OP_POST_RETRACE, 2'd3);
        send_op(fbsm_pkg::OP_EFB_DRAWN, 2'd1);

        // single buffer, period of one retrace: embedded buffer copy path
        settle();
        cfg_write(fbsm_pkg::REG_PRESENT_MASK, 32'd1);
        cfg_write(fbsm_pkg::REG_RETRACE_PERIOD, 32'd1);
        cur_mask = 3'd1;
        send_op(fbsm_pkg::OP_INIT, 2'd0);
        send_op(fbsm_pkg::OP_ACQUIRE, 2'd0);
        send_op(fbsm_pkg::OP_PRE_RETRACE, 2'd0);
        send_op(fbsm_pkg::OP_SETTINGS_CHG, 2'd0);
        send_op(fbsm_pkg::OP_EFB_DRAWN, 2'd0);
        send_op(fbsm_pkg::OP_PRE_RETRACE, 2'd0);
        send_op(fbsm_pkg::OP_POST_RETRACE, 2'd0);
        send_op(fbsm_pkg::OP_EFB_DRAWN, 2'd0);
        send_op(fbsm_pkg::OP_PRE_RETRACE, 2'd0);
        // copy still pending: no display or free buffer to take
        send_op(fbsm_pkg::OP_EFB_DRAWN, 2'd0);
        send_op(fbsm_pkg::OP_PRE_RETRACE, 2'd0);

        for (int p = 0; p < N_PHASES; p++) begin
            settle();
            if ($urandom_range(0, 1) == 0) begin
                cfg_write(fbsm_pkg::REG_PRESENT_MASK, fbsm_pkg::APB_DW'(PHASE_MASK[p]));
                cfg_write(fbsm_pkg::REG_RETRACE_PERIOD, fbsm_pkg::APB_DW'(PHASE_PERIOD[p]));
            end else begin
                cfg_write(fbsm_pkg::REG_RETRACE_PERIOD, fbsm_pkg::APB_DW'(PHASE_PERIOD[p]));
                cfg_write(fbsm_pkg::REG_PRESENT_MASK, fbsm_pkg::APB_DW'(PHASE_MASK[p]));
            end
            cur_mask = PHASE_MASK[p];
            idle_en <= (p != N_PHASES - 1);
            target = items_sent + ((PHASE_MASK[p] == 3'd0) ? 30 : 170);
            if ($urandom_range(0, 3) != 0) send_op(fbsm_pkg::OP_INIT, any_bi());
            while (items_sent < target) begin
                if (p != N_PHASES - 1 && $urandom_range(0, 19) == 0) idle_en <= !idle_en;
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    send_op(fbsm_pkg::OP_INIT, any_bi());
                else if (pick < 22)
                    send_op(fbsm_pkg::t_opcode'($urandom_range(0, 7)), any_bi());
                else
                    play_frame();
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
